// ===== rtl/core/sorted_set_range_delete_macros.svh =====
// Assertion macros for the sorted set with range delete.
`ifndef SORTED_SET_RANGE_DELETE_MACROS_SVH
`define SORTED_SET_RANGE_DELETE_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge out of reset.
`define SSRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen out of reset.
`define SSRD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SSRD_ASSERT(lbl, prop, msg)
`define SSRD_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/ssrd_pkg.sv =====
// Shared types and constants of the sorted set with range delete.
package ssrd_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_PORT_W = 32;
  localparam int RAD_PORT_W = 31;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_BLAST      = 2'd1,
    OP_PRINT_ASC  = 2'd2,
    OP_PRINT_DESC = 2'd3
  } op_e;

endpackage

// ===== rtl/core/ssrd_req_if.sv =====
// Request channel of the sorted set: operation, key and radius.
interface ssrd_req_if;
  import ssrd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [KEY_PORT_W-1:0] key_value;
  logic [RAD_PORT_W-1:0] radius;

  modport source (output valid, output op, output key_value, output radius, input ready);
  modport sink   (input valid, input op, input key_value, input radius, output ready);
endinterface

// ===== rtl/core/ssrd_rsp_if.sv =====
// Result channel of the sorted set: one printed key per transfer.
interface ssrd_rsp_if;
  import ssrd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_PORT_W-1:0] out_key;
  logic                  last;
  logic                  overflowed;

  modport source (output valid, output out_key, output last, output overflowed, input ready);
  modport sink   (input valid, input out_key, input last, input overflowed, output ready);
endinterface

// ===== rtl/core/sorted_set_range_delete.sv =====
// Sorted set of distinct signed keys with insert, range delete and ordered print.
//
// Up to CAPACITY distinct keys of KEY_WIDTH bits are held ascending in one
// synchronous single-port-read memory (one read and one write per cycle, read
// data registered). A request is taken only while no earlier request is being
// worked on; a printed key still waiting in the result register does not hold
// off the next request. An insert is an ascending scan that writes the new key
// into its slot and carries each larger key up one place, then the write of
// the last carried key; a blast is an ascending scan that compacts surviving
// keys in place; a print is a scan that the result side can stall. The scan
// reads one entry per cycle unless a print waits on the result register, so
// the memory read port sets the pace. A duplicate insert stops at the matching
// key before anything is written. An insert into a full set that would add a
// new key is dropped and sets the sticky overflow flag, reported with each
// printed key. A print of an empty set gives no result. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
`include "sorted_set_range_delete_macros.svh"

module sorted_set_range_delete #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssrd_req_if.sink   req_i,
  ssrd_rsp_if.source rsp_o
);
  import ssrd_pkg::*;

  localparam int KW = KEY_WIDTH;
  localparam int RW = KEY_WIDTH - 1;   // radius bits used
  localparam int BW = KEY_WIDTH + 1;   // blast bounds, one bit wider than a key
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;

  // ---------------------------------------------------------------------------
  // Port field mapping: low KEY_WIDTH bits of the key, low KEY_WIDTH-1 bits of
  // the radius; printed keys are the raw KEY_WIDTH-bit pattern.
  // ---------------------------------------------------------------------------
  logic [KW-1:0] key_in;
  logic [RW-1:0] rad_in;
  logic [KW-1:0] out_key_q;

  if (KW <= KEY_PORT_W) begin : g_key_narrow
    assign key_in = req_i.key_value[KW-1:0];
  end else begin : g_key_wide
    assign key_in = {{(KW-KEY_PORT_W){1'b0}}, req_i.key_value};
  end

  if (RW <= RAD_PORT_W) begin : g_rad_narrow
    assign rad_in = req_i.radius[RW-1:0];
  end else begin : g_rad_wide
    assign rad_in = {{(RW-RAD_PORT_W){1'b0}}, req_i.radius};
  end

  if (KW >= KEY_PORT_W) begin : g_out_wide
    assign rsp_o.out_key = out_key_q[KEY_PORT_W-1:0];
  end else begin : g_out_narrow
    assign rsp_o.out_key = {{(KEY_PORT_W-KW){1'b0}}, out_key_q};
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [1:0]           state_q, state_d;
  op_e                  op_q, op_d;
  logic [KW-1:0]        key_q, key_d;          // insert key, then carried key
  logic signed [BW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]        cnt_q, cnt_d;          // fill count
  logic                 ovf_q, ovf_d;          // sticky overflow
  logic [IW-1:0]        rd_ptr_q, rd_ptr_d;    // next entry to read
  logic [CW-1:0]        left_q, left_d;        // reads still to issue
  logic                 s1_vld_q, s1_vld_d;    // read data holds a live entry
  logic [IW-1:0]        s1_idx_q, s1_idx_d;
  logic                 s1_last_q, s1_last_d;
  logic [CW-1:0]        wr_cnt_q, wr_cnt_d;    // blast compaction pointer
  logic [IW-1:0]        place_q, place_d;      // insert slot
  logic [KW-1:0]        rd_data_q;
  logic                 out_vld_q, out_vld_d;
  logic                 out_last_q, out_ovf_q;

  logic [KW-1:0] key_mem_q [CAPACITY];

  // Memory port controls
  logic          rd_en;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;

  logic                 acc, full, desc, is_print, out_free, take, stop, out_load;
  logic                 eq, lt, in_rng;
  logic signed [BW-1:0] d_ext;
  logic [CW-1:0]        cnt_m1, wr_cnt_nx;
  op_e                  req_op;

  assign req_op   = op_e'(req_i.op);
  assign acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign full     = (cnt_q == CAP_CNT);
  assign cnt_m1   = cnt_q - CW'(1);
  assign desc     = (op_q == OP_PRINT_DESC);
  assign is_print = (op_q == OP_PRINT_ASC) || (op_q == OP_PRINT_DESC);
  assign out_free = !out_vld_q || rsp_o.ready;
  // scan stage can move on this cycle
  assign take     = !s1_vld_q || !is_print || out_free;

  assign eq     = ($signed(rd_data_q) == $signed(key_q));
  assign lt     = ($signed(rd_data_q) <  $signed(key_q));
  assign d_ext  = $signed({rd_data_q[KW-1], rd_data_q});
  assign in_rng = (d_ext >= lo_q) && (d_ext <= hi_q);
  assign wr_cnt_nx = wr_cnt_q + CW'(!in_rng);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    rd_ptr_d  = rd_ptr_q;
    left_d    = left_q;
    s1_vld_d  = s1_vld_q;
    s1_idx_d  = s1_idx_q;
    s1_last_d = s1_last_q;
    wr_cnt_d  = wr_cnt_q;
    place_d   = place_q;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = s1_idx_q + IW'(1);
    mem_wdata = rd_data_q;
    stop      = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          op_d     = req_op;
          key_d    = key_in;
          lo_d     = $signed({key_in[KW-1], key_in}) - $signed({2'b00, rad_in});
          hi_d     = $signed({key_in[KW-1], key_in}) + $signed({2'b00, rad_in});
          wr_cnt_d = '0;
          left_d   = cnt_q;
          rd_ptr_d = (req_op == OP_PRINT_DESC) ? cnt_m1[IW-1:0] : '0;
          if (cnt_q != '0) begin
            state_d = S_SCAN;
          end else if (req_op == OP_INSERT) begin
            place_d = '0;
            state_d = S_PLACE;
          end
        end
      end

      S_SCAN: begin
        if (s1_vld_q) begin
          case (op_q)
            OP_INSERT: begin
              if (eq) begin
                // already present: nothing written yet, set unchanged
                stop    = 1'b1;
                state_d = S_IDLE;
              end else if (lt) begin
                // slot lies further up
                if (s1_last_q) begin
                  place_d = s1_idx_q + IW'(1);
                  state_d = S_PLACE;
                end
              end else if (full) begin
                // new key into a full set: dropped, flag set in place state
                stop    = 1'b1;
                state_d = S_PLACE;
              end else begin
                // larger key: carried key goes here, this one moves up
                mem_we    = 1'b1;
                mem_waddr = s1_idx_q;
                mem_wdata = key_q;
                key_d     = rd_data_q;
                if (s1_last_q) begin
                  place_d = s1_idx_q + IW'(1);
                  state_d = S_PLACE;
                end
              end
            end
            OP_BLAST: begin
              mem_we    = !in_rng;
              mem_waddr = wr_cnt_q[IW-1:0];
              wr_cnt_d  = wr_cnt_nx;
              if (s1_last_q) begin
                cnt_d   = wr_cnt_nx;
                state_d = S_IDLE;
              end
            end
            default: begin
              if (out_free) begin
                out_load = 1'b1;
                if (s1_last_q) state_d = S_IDLE;
              end
            end
          endcase
        end

        if ((left_q != '0) && take && !stop) begin
          rd_en     = 1'b1;
          rd_ptr_d  = desc ? rd_ptr_q - IW'(1) : rd_ptr_q + IW'(1);
          left_d    = left_q - CW'(1);
          s1_vld_d  = 1'b1;
          s1_idx_d  = rd_ptr_q;
          s1_last_d = (left_q == CW'(1));
        end else if (s1_vld_q && take) begin
          s1_vld_d = 1'b0;
        end
      end

      S_PLACE: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = place_q;
          mem_wdata = key_q;
          cnt_d     = cnt_q + CW'(1);
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_INSERT;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      rd_ptr_q  <= '0;
      left_q    <= '0;
      s1_vld_q  <= 1'b0;
      s1_idx_q  <= '0;
      s1_last_q <= 1'b0;
      wr_cnt_q  <= '0;
      place_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      rd_ptr_q  <= rd_ptr_d;
      left_q    <= left_d;
      s1_vld_q  <= s1_vld_d;
      s1_idx_q  <= s1_idx_d;
      s1_last_q <= s1_last_d;
      wr_cnt_q  <= wr_cnt_d;
      place_q   <= place_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    if (out_load) begin
      out_key_q  <= rd_data_q;
      out_last_q <= s1_last_q;
      out_ovf_q  <= ovf_q;
    end
  end

  // Key memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) key_mem_q[mem_waddr] <= mem_wdata;
    if (rd_en)  rd_data_q <= key_mem_q[rd_ptr_q];
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.last       = out_last_q;
  assign rsp_o.overflowed = out_ovf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SSRD_NEVER(a_cnt_in_range, cnt_q > CAP_CNT, "fill count above capacity")
  `SSRD_ASSERT(a_ovf_sticky, ovf_q |=> ovf_q, "overflow flag cleared")
  `SSRD_NEVER(a_idle_drained, (state_q == S_IDLE) && s1_vld_q, "scan data left on return to idle")
  `SSRD_ASSERT(a_grow_on_place, (cnt_q <= $past(cnt_q)) || ($past(state_q) == S_PLACE), "fill count grew outside insert")
  `SSRD_ASSERT(a_load_in_print, out_load |-> (is_print && (state_q == S_SCAN)), "result loaded outside a print")

endmodule

// ===== dv/sorted_set_range_delete_checker.sv =====
// Checker for the sorted set: predicts printed keys from accepted requests and compares them.
module sorted_set_range_delete_checker #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssrd_req_if  req_i,
  ssrd_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import ssrd_pkg::*;

  localparam logic [63:0] KEY_MASK = (64'd1 << KEY_WIDTH) - 64'd1;
  localparam logic [63:0] KEY_SIGN = 64'd1 << (KEY_WIDTH - 1);
  localparam logic [63:0] RAD_MASK = KEY_SIGN - 64'd1;

  typedef struct packed {
    logic [KEY_PORT_W-1:0] out_key;
    logic                  last;
    logic                  overflowed;
  } printed_key_t;

  longint       set_keys[$];       // ascending, as held by the block
  logic         overflow_seen;
  printed_key_t awaited_keys[$];

  // Apply one request to the shadow set; prints queue the keys they emit.
  task automatic apply_request(input logic [OP_W-1:0] op_bits,
                               input logic [KEY_PORT_W-1:0] key_bits,
                               input logic [RAD_PORT_W-1:0] rad_bits);
    op_e          op;
    longint       key;
    longint       rad;
    longint       lo;
    longint       hi;
    longint       kept[$];
    int           pos;
    int           n;
    int           idx;
    printed_key_t item;
    op  = op_e'(op_bits);
    key = longint'((64'(key_bits) & KEY_MASK) ^ KEY_SIGN) - longint'(KEY_SIGN);
    rad = longint'(64'(rad_bits) & RAD_MASK);
    case (op)
      OP_INSERT: begin
        pos = 0;
        while (pos < set_keys.size() && set_keys[pos] < key) pos++;
        if (!(pos < set_keys.size() && set_keys[pos] == key)) begin
          if (set_keys.size() >= CAPACITY) begin
            overflow_seen = 1'b1;
          end else begin
            set_keys.insert(pos, key);
          end
        end
      end
      OP_BLAST: begin
        // bounds in 64 bits, so no wrap at the key extremes
        lo = key - rad;
        hi = key + rad;
        foreach (set_keys[i]) begin
          if (set_keys[i] < lo || set_keys[i] > hi) kept.push_back(set_keys[i]);
        end
        set_keys = kept;
      end
      default: begin
        n = set_keys.size();
        for (int k = 0; k < n; k++) begin
          idx = (op == OP_PRINT_ASC) ? k : n - 1 - k;
          item.out_key    = KEY_PORT_W'(64'(set_keys[idx]) & KEY_MASK);
          item.last       = (k == n - 1);
          item.overflowed = overflow_seen;
          awaited_keys.push_back(item);
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    end
  endtask

  // Results are checked before the request of the same edge is applied:
  // a key leaving now always belongs to an earlier print.
  always @(posedge clk_i or negedge rst_ni) begin
    printed_key_t want;
    if (!rst_ni) begin
      set_keys.delete();
      awaited_keys.delete();
      overflow_seen = 1'b0;
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_keys.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result: expected none, got key %h last %b overflowed %b",
                   $time, rsp_i.out_key, rsp_i.last, rsp_i.overflowed);
        end else begin
          want = awaited_keys.pop_front();
          check_field("out_key", want.out_key, rsp_i.out_key);
          check_field("last", 32'(want.last), 32'(rsp_i.last));
          check_field("overflowed", 32'(want.overflowed), 32'(rsp_i.overflowed));
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_request(req_i.op, req_i.key_value, req_i.radius);
      end
      pending_o = awaited_keys.size();
    end
  end

endmodule

// ===== dv/sorted_set_range_delete_test.sv =====
// Top of the sorted set test: clock, reset, request and result drivers, watchdog and verdict.
module sorted_set_range_delete_test;
  import ssrd_pkg::*;

  localparam int CAPACITY        = 64;
  localparam int KEY_WIDTH       = 32;
  // Worst quiet stretch: a full-set scan plus the long result hold-off.
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  // A scan of a full set plus the pipeline around it.
  localparam int DRAIN_CYCLES    = CAPACITY + 8;
  localparam int RANDOM_ITEMS    = 20;
  localparam int FINAL_ITEMS     = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   idle_on  = 1'b1;   // random gaps on both sides
  bit   hold_off = 1'b0;   // asks the receiver for its one long result stall

  ssrd_req_if req_ch ();
  ssrd_rsp_if rsp_ch ();

  sorted_set_range_delete #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  sorted_set_range_delete_checker #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: counts cycles with no request and no result moving.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: ready mostly high, short random stalls, and one long
  // hold-off on request from the stimulus so the block backs up.
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off && !held) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Key mix: mostly a narrow band so duplicates and blast hits are common,
  // some full-range values, some extremes.
  function automatic logic [KEY_PORT_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 100)) - 50;
      5, 6:          return $urandom();
      7:             return 32'h7fff_ffff;
      8:             return 32'h8000_0000;
      default:       return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [RAD_PORT_W-1:0] pick_radius();
    case ($urandom_range(0, 9))
      7, 8:    return RAD_PORT_W'($urandom());
      9:       return {RAD_PORT_W{1'b1}};
      default: return RAD_PORT_W'($urandom_range(0, 20));
    endcase
  endfunction

  // Enters and leaves at a falling edge. An optional gap lowers valid first;
  // otherwise valid stays high straight into the next request.
  task automatic push_request(input op_e op, input logic [KEY_PORT_W-1:0] key,
                              input logic [RAD_PORT_W-1:0] rad);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.key_value <= key;
    req_ch.radius    <= rad;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // Weighted towards inserts so the set grows; unused fields carry noise.
  task automatic push_random_request();
    int  pick;
    op_e op;
    pick = $urandom_range(0, 19);
    if (pick < 11)      op = OP_INSERT;
    else if (pick < 14) op = OP_BLAST;
    else if (pick < 17) op = OP_PRINT_ASC;
    else                op = OP_PRINT_DESC;
    push_request(op, pick_key(), pick_radius());
  endtask

  initial begin
    int                    base;
    logic [KEY_PORT_W-1:0] first_fill;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_INSERT;
    req_ch.key_value = '0;
    req_ch.radius    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty prints, key extremes, duplicates, blasts at the ends
    // of the key range with the widest radius, and a blast that hits nothing.
    push_request(OP_PRINT_ASC, '0, '0);
    push_request(OP_PRINT_DESC, $urandom(), RAD_PORT_W'($urandom()));
    push_request(OP_BLAST, '0, {RAD_PORT_W{1'b1}});
    push_request(OP_INSERT, 32'h7fff_ffff, '0);
    push_request(OP_INSERT, 32'h8000_0000, {RAD_PORT_W{1'b1}});
    push_request(OP_INSERT, 32'h0, '0);
    push_request(OP_INSERT, 32'hffff_ffff, '0);
    push_request(OP_INSERT, 32'h1, '0);
    push_request(OP_INSERT, 32'h0, '0);
    push_request(OP_INSERT, 32'h7fff_ffff, '0);
    push_request(OP_PRINT_ASC, '0, '0);
    push_request(OP_PRINT_DESC, '0, '0);
    push_request(OP_BLAST, 32'h0, '0);
    push_request(OP_BLAST, 32'd1000, 31'd5);
    push_request(OP_PRINT_ASC, '0, '0);
    // upper bound runs past the top key
    push_request(OP_BLAST, 32'h7fff_ffff, {RAD_PORT_W{1'b1}});
    push_request(OP_PRINT_DESC, '0, '0);
    push_request(OP_INSERT, 32'd5, '0);
    push_request(OP_INSERT, -32'sd5, '0);
    // lower bound runs past the bottom key
    push_request(OP_BLAST, 32'h8000_0000, {RAD_PORT_W{1'b1}});
    push_request(OP_PRINT_ASC, '0, '0);
    push_request(OP_BLAST, 32'd5, '0);
    push_request(OP_PRINT_DESC, '0, '0);

    // Random requests, with the long result hold-off and one full drain
    // part way through.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 8) begin
        hold_off = 1'b1;
        push_request(OP_INSERT, pick_key(), '0);
        push_request(OP_PRINT_ASC, '0, '0);
      end
      if (i == 15) begin
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      push_random_request();
    end

    // Fill past capacity with distinct keys, then a duplicate and a new key
    // into the full set; the overflow flag stays set from here on.
    base = int'($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000;
    for (int i = 0; i < CAPACITY + 6; i++) begin
      if (i == 0) begin
        first_fill = base + int'($urandom_range(0, 2047));
        push_request(OP_INSERT, first_fill, pick_radius());
      end else begin
        push_request(OP_INSERT, base + i * 2048 + int'($urandom_range(0, 2047)), '0);
      end
    end
    push_request(OP_PRINT_ASC, '0, '0);
    push_request(OP_INSERT, first_fill, '0);
    push_request(OP_INSERT, base - 1, '0);
    push_request(OP_PRINT_DESC, '0, '0);
    push_request(OP_BLAST, base + 32 * 2048, 31'd20000);
    push_request(OP_PRINT_ASC, '0, '0);

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    for (int i = 0; i < FINAL_ITEMS; i++) push_random_request();
    req_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    // let any insert or blast still in work finish before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
